// ===== rtl/u8u16_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; used by u8u16_decode, u8u16_outbuf and the top level.
package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
    localparam logic [20:0] MAX_CODE    = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h010000;
    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;   // 0xD800 >> 10
    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;   // 0xDC00 >> 10
    localparam int unsigned MAX_UNITS   = 4;

    // Sequence decoder state
    typedef struct packed {
        logic [1:0]  need;   // continuation bytes still expected in total, 0 = idle
        logic [1:0]  got;    // continuation bytes received
        logic [20:0] acc;    // code point bits gathered so far
    } seq_state_t;

    // Units produced by one input byte
    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;        // index 0 goes out first
        logic [2:0]                 count;        // 0 to MAX_UNITS
        logic                       stream_last;
    } unit_group_t;

endpackage

// ===== rtl/u8u16_decode.sv =====
// Combinational UTF-8 byte decoder: one byte plus sequence state in,
// up to four UTF-16 units and the next state out. Depends on u8u16_pkg.
module u8u16_decode (
    input  logic [7:0]              in_byte,
    input  logic                    is_last,
    input  u8u16_pkg::seq_state_t   st,
    output u8u16_pkg::seq_state_t   st_next,
    output u8u16_pkg::unit_group_t  res
);

    logic        cont;
    logic        pending;
    logic [20:0] acc_ext;
    logic [1:0]  got_inc;
    logic [20:0] min_code;
    logic        bad_code;
    logic [19:0] supp_off;
    logic        lead_ascii;
    logic        lead_bad;
    logic [1:0]  lead_need;
    logic [20:0] lead_bits;
    logic [2:0]  base;

    assign cont    = (in_byte[7:6] == 2'b10);
    assign pending = (st.need != 2'd0);
    assign acc_ext = {st.acc[14:0], in_byte[5:0]};
    assign got_inc = st.got + 2'd1;

    always_comb begin
        unique case (st.need)
            2'd1:    min_code = 21'h000080;
            2'd2:    min_code = 21'h000800;
            default: min_code = u8u16_pkg::SUPP_BASE;
        endcase
    end

    // overlong, beyond the Unicode range, or an encoded surrogate
    assign bad_code = (acc_ext < min_code) || (acc_ext > u8u16_pkg::MAX_CODE) ||
                      (acc_ext[20:11] == 10'b0000011011);
    assign supp_off = 20'(acc_ext - u8u16_pkg::SUPP_BASE);

    always_comb begin
        lead_ascii = 1'b0;
        lead_bad   = 1'b0;
        lead_need  = 2'd0;
        lead_bits  = '0;
        if (in_byte[7] == 1'b0) begin
            lead_ascii = 1'b1;
        end else if (in_byte[7:5] == 3'b110) begin
            lead_need = 2'd1;
            lead_bits = {16'd0, in_byte[4:0]};
        end else if (in_byte[7:4] == 4'b1110) begin
            lead_need = 2'd2;
            lead_bits = {17'd0, in_byte[3:0]};
        end else if (in_byte[7:3] == 5'b11110) begin
            lead_need = 2'd3;
            lead_bits = {18'd0, in_byte[2:0]};
        end else begin
            lead_bad = 1'b1;
        end
    end

    // replacements owed by a broken pending sequence come first
    assign base = pending ? ({1'b0, st.got} + 3'd1) : 3'd0;

    always_comb begin
        res             = '0;
        res.units       = {u8u16_pkg::MAX_UNITS{u8u16_pkg::REPL_UNIT}};
        res.count       = 3'd0;
        res.stream_last = is_last;
        st_next         = st;
        if (pending && cont) begin
            if (got_inc >= st.need) begin
                st_next = '0;
                if (bad_code) begin
                    res.count = 3'd1;
                end else if (acc_ext >= u8u16_pkg::SUPP_BASE) begin
                    res.units[0] = {u8u16_pkg::HI_SURR_TAG, supp_off[19:10]};
                    res.units[1] = {u8u16_pkg::LO_SURR_TAG, supp_off[9:0]};
                    res.count    = 3'd2;
                end else begin
                    res.units[0] = acc_ext[15:0];
                    res.count    = 3'd1;
                end
            end else if (is_last) begin
                st_next   = '0;
                res.count = {1'b0, got_inc} + 3'd1;
            end else begin
                st_next.got = got_inc;
                st_next.acc = acc_ext;
            end
        end else begin
            st_next = '0;
            if (lead_ascii) begin
                res.units[base[1:0]] = {8'h00, in_byte};
                res.count            = base + 3'd1;
            end else if (lead_bad || is_last) begin
                res.count = base + 3'd1;
            end else begin
                res.count    = base;
                st_next.need = lead_need;
                st_next.acc  = lead_bits;
            end
        end
        if (is_last) begin
            st_next = '0;
        end
    end

endmodule

// ===== rtl/u8u16_outbuf.sv =====
// Result register: holds the units of one input byte and drains them one
// per transfer on the master side. Depends on u8u16_pkg.
module u8u16_outbuf (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  u8u16_pkg::unit_group_t  res,
    output logic                    can_load,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [15:0]             m_tdata,   // [15:0] out_unit
    output logic                    m_tlast,   // run_last
    output logic                    m_tuser    // stream_last
);

    logic [u8u16_pkg::MAX_UNITS-1:0][15:0] units_reg;
    logic [2:0]                            rem_reg;
    logic                                  slast_reg;
    logic                                  one_left;

    assign one_left = (rem_reg == 3'd1);
    assign m_tvalid = (rem_reg != 3'd0);
    assign m_tdata  = units_reg[0];
    assign m_tlast  = one_left;
    assign m_tuser  = slast_reg && one_left;
    // refill in the same cycle as the final unit goes out
    assign can_load = (rem_reg == 3'd0) || (one_left && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 3'd0;
        end else if (load) begin
            rem_reg <= res.count;
        end else if (m_tvalid && m_tready) begin
            rem_reg <= rem_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            units_reg <= res.units;
            slast_reg <= res.stream_last;
        end else if (m_tvalid && m_tready) begin
            units_reg <= {16'd0, units_reg[u8u16_pkg::MAX_UNITS-1:1]};
        end
    end

endmodule

// ===== rtl/utf8_to_utf16_transcoder_core.sv =====
// UTF-8 to UTF-16 transcoder top level: sequence state register, decoder
// and result register. Depends on u8u16_pkg, u8u16_decode, u8u16_outbuf.
//
// Takes one UTF-8 byte per transfer (s_tlast on the final byte of the text)
// and gives UTF-16 code units, one per transfer, with m_tlast on the last
// unit caused by a byte and m_tuser on the final unit of the stream. A byte
// is decoded in the cycle it is accepted and its units are registered, so a
// byte that yields zero or one unit is taken every cycle while m_tready is
// high. A byte that yields n units (surrogate pair, or a run of U+FFFD for a
// broken sequence, up to four) holds the input while the result register
// drains; the next byte is taken in the cycle the last unit is transferred.
// Malformed input becomes U+FFFD; decoding resynchronises on the next byte.
module utf8_to_utf16_transcoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] out_unit
    output logic        m_tlast,    // run_last
    output logic        m_tuser     // stream_last
);

    u8u16_pkg::seq_state_t  seq_reg;
    u8u16_pkg::seq_state_t  seq_next;
    u8u16_pkg::unit_group_t dec_res;
    logic                   can_load;
    logic                   in_xfer;

    assign s_tready = can_load;
    assign in_xfer  = s_tvalid && can_load;

    u8u16_decode u_decode (
        .in_byte (s_tdata),
        .is_last (s_tlast),
        .st      (seq_reg),
        .st_next (seq_next),
        .res     (dec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg <= '0;
        end else if (in_xfer) begin
            seq_reg <= seq_next;
        end
    end

    u8u16_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (in_xfer),
        .res      (dec_res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for utf8_to_utf16_transcoder_core: directed table then random
// UTF-8 streams, each unit checked against an in-bench UTF-8 decoder. Depends on u8u16_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 425;
    localparam int HOLD_LEN   = 80;
    localparam int TAIL_WAIT  = 20;

    typedef struct packed {
        logic [7:0]  data;
        logic        fin;      // final byte of the text
        logic        typed;    // expected unit given in the table
        logic [15:0] unit;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] unit;
        logic        run_last;
        logic        stream_last;
    } utf16_unit_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    utf8_to_utf16_transcoder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Directed table; expected unit typed in only where it is obvious
    byte_item_t directed_tab [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, 16'h0000},                 // lowest ASCII
        '{8'h7F, 1'b0, 1'b1, 16'h007F},                 // highest ASCII
        '{8'h80, 1'b0, 1'b1, u8u16_pkg::REPL_UNIT},     // stray continuation as lead
        '{8'hFF, 1'b0, 1'b1, u8u16_pkg::REPL_UNIT},     // never-valid lead
        '{8'hC0, 1'b0, 1'b0, 16'h0000},                 // overlong NUL
        '{8'h80, 1'b0, 1'b1, u8u16_pkg::REPL_UNIT},
        '{8'hED, 1'b0, 1'b0, 16'h0000},                 // encoded surrogate
        '{8'hA0, 1'b0, 1'b0, 16'h0000},
        '{8'h80, 1'b0, 1'b1, u8u16_pkg::REPL_UNIT},
        '{8'hF0, 1'b0, 1'b0, 16'h0000},                 // U+1F600, surrogate pair
        '{8'h9F, 1'b0, 1'b0, 16'h0000},
        '{8'h98, 1'b0, 1'b0, 16'h0000},
        '{8'h80, 1'b0, 1'b0, 16'h0000},
        '{8'hF4, 1'b0, 1'b0, 16'h0000},                 // above U+10FFFF
        '{8'h90, 1'b0, 1'b0, 16'h0000},
        '{8'h80, 1'b0, 1'b0, 16'h0000},
        '{8'h80, 1'b0, 1'b1, u8u16_pkg::REPL_UNIT},
        '{8'hF0, 1'b0, 1'b0, 16'h0000},                 // broken by ASCII: four units
        '{8'h90, 1'b0, 1'b0, 16'h0000},
        '{8'h80, 1'b0, 1'b0, 16'h0000},
        '{8'h7A, 1'b0, 1'b0, 16'h0000},
        '{8'hE2, 1'b0, 1'b0, 16'h0000},                 // cut short by end of text
        '{8'h82, 1'b1, 1'b0, 16'h0000},
        '{8'hC3, 1'b1, 1'b1, u8u16_pkg::REPL_UNIT},     // lead as final byte
        '{8'h41, 1'b1, 1'b1, 16'h0041}
    };

    byte_item_t  stim_q [$];
    utf16_unit_t exp_units_q [$];
    logic [15:0] byte_units [$];    // units caused by the byte being decoded

    // decoder state mirror
    logic [1:0]  seq_need = '0;
    logic [1:0]  seq_got  = '0;
    logic [20:0] seq_acc  = '0;

    logic        cur_typed;
    logic [15:0] cur_unit;
    int          send_pct;
    int          recv_pct;
    bit          hold_req;
    int          err_cnt;

    // ---------------- decoder -----------------

    function automatic void add_byte_unit(input logic [15:0] u);
        byte_units = {byte_units, u};
    endfunction

    function automatic void flush_seq();
        add_byte_unit(u8u16_pkg::REPL_UNIT);
        for (int i = 0; i < seq_got; i++) add_byte_unit(u8u16_pkg::REPL_UNIT);
        seq_need = '0;
        seq_got  = '0;
        seq_acc  = '0;
    endfunction

    function automatic void start_seq(input logic [7:0] b, input logic fin);
        if (b[7] == 1'b0) begin
            add_byte_unit({8'h00, b});
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
            if (fin) begin
                add_byte_unit(u8u16_pkg::REPL_UNIT);
            end else if (b[7:5] == 3'b110) begin
                seq_need = 2'd1;
                seq_acc  = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                seq_need = 2'd2;
                seq_acc  = {17'd0, b[3:0]};
            end else begin
                seq_need = 2'd3;
                seq_acc  = {18'd0, b[2:0]};
            end
            seq_got = '0;
        end else begin
            add_byte_unit(u8u16_pkg::REPL_UNIT);
        end
    endfunction

    function automatic void transcode_byte(input logic [7:0] b, input logic fin);
        logic [20:0] cp;
        logic [20:0] floor_cp;
        logic [20:0] v;
        byte_units.delete();
        if (seq_need != 0) begin
            if (b[7:6] == 2'b10) begin
                seq_acc = {seq_acc[14:0], b[5:0]};
                seq_got = seq_got + 2'd1;
                if (seq_got >= seq_need) begin
                    cp = seq_acc;
                    floor_cp = (seq_need == 2'd1) ? 21'h80 :
                               (seq_need == 2'd2) ? 21'h800 : u8u16_pkg::SUPP_BASE;
                    if (cp < floor_cp || cp > u8u16_pkg::MAX_CODE ||
                        (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
                        add_byte_unit(u8u16_pkg::REPL_UNIT);
                    end else if (cp >= u8u16_pkg::SUPP_BASE) begin
                        v = cp - u8u16_pkg::SUPP_BASE;
                        add_byte_unit({u8u16_pkg::HI_SURR_TAG, v[19:10]});
                        add_byte_unit({u8u16_pkg::LO_SURR_TAG, v[9:0]});
                    end else begin
                        add_byte_unit(cp[15:0]);
                    end
                    seq_need = '0;
                    seq_got  = '0;
                    seq_acc  = '0;
                end else if (fin) begin
                    flush_seq();
                end
            end else begin
                flush_seq();
                start_seq(b, fin);
            end
        end else begin
            start_seq(b, fin);
        end
        if (fin) begin
            seq_need = '0;
            seq_got  = '0;
            seq_acc  = '0;
        end
    endfunction

    // ---------------- random text -----------------

    function automatic void push_byte(input logic [7:0] b);
        byte_item_t itm;
        itm    = '{b, ($urandom_range(39) == 0), 1'b0, 16'h0000};
        stim_q = {stim_q, itm};
    endfunction

    // keep: how many bytes of the encoding to actually send
    function automatic void encode_utf8(input logic [20:0] cp, input int len, input int keep);
        logic [7:0] enc [4];
        case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++) push_byte(enc[i]);
    endfunction

    function automatic void append_sequence();
        int          r;
        int          len;
        logic [20:0] cp;
        r   = $urandom_range(99);
        len = $urandom_range(1, 4);
        case (len)
            1: cp = 21'($urandom_range(0, 16'h7F));
            2: cp = 21'($urandom_range(16'h80, 16'h7FF));
            3: begin
                cp = 21'($urandom_range(16'h800, 16'hFFFF));
                if (cp >= 21'hD800 && cp <= 21'hDFFF) cp[12] = 1'b0;
            end
            default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
        endcase
        if (r < 50) begin
            encode_utf8(cp, len, len);
        end else if (r < 62) begin
            case ($urandom_range(2))
                0: encode_utf8(cp, (len == 4) ? 4 : len + 1, (len == 4) ? 4 : len + 1);
                1: encode_utf8(21'($urandom_range(16'hD800, 16'hDFFF)), 3, 3);
                default: encode_utf8(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4, 4);
            endcase
            // first case with len 4 stays valid, which is harmless
        end else if (r < 80) begin
            len = (len == 1) ? 2 : len;
            encode_utf8(cp, len, $urandom_range(1, len - 1));
        end else begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
        end
    endfunction

    // ---------------- clock and reset -----------------

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // ---------------- result side -----------------

    initial begin
        int unsigned hold_left;
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready  <= 1'b0;
                hold_left = hold_left - 1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_pct);
            end
        end
    end

    // ---------------- monitor and scoreboard -----------------

    task automatic report_error(input string what, input utf16_unit_t want,
                                input utf16_unit_t got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t ERROR %s: expected unit %h last %b end %b, got unit %h last %b end %b",
                     $realtime, what, want.unit, want.run_last, want.stream_last,
                     got.unit, got.run_last, got.stream_last);
    endtask

    always @(posedge aclk) begin
        utf16_unit_t got;
        utf16_unit_t want;
        utf16_unit_t exp_u;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                transcode_byte(s_tdata, s_tlast);
                if (cur_typed) begin
                    byte_units.delete();
                    add_byte_unit(cur_unit);
                end
                foreach (byte_units[i]) begin
                    exp_u = '{byte_units[i], (i == byte_units.size() - 1),
                              (i == byte_units.size() - 1) && s_tlast};
                    exp_units_q = {exp_units_q, exp_u};
                end
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata, m_tlast, m_tuser};
                if (exp_units_q.size() == 0) begin
                    report_error("unit with nothing pending", '0, got);
                end else begin
                    want = exp_units_q.pop_front();
                    if (got !== want) report_error("unit mismatch", want, got);
                end
            end
        end
    end

    // ---------------- input side and run control -----------------

    initial begin
        int         gap;
        int         rand_idx;
        byte_item_t item;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cur_typed = 1'b0;
        cur_unit  = '0;
        send_pct  = 14;
        recv_pct  = 68;
        hold_req  = 1'b0;
        err_cnt   = 0;
        foreach (directed_tab[i]) stim_q = {stim_q, directed_tab[i]};
        while (stim_q.size() < N_DIRECTED + N_RANDOM) append_sequence();

        wait (aresetn === 1'b1);
        @(negedge aclk);
        foreach (stim_q[i]) begin
            item     = stim_q[i];
            rand_idx = i - N_DIRECTED;
            if (rand_idx == N_RANDOM / 3) begin
                send_pct = 68;
                recv_pct = 14;
            end else if (rand_idx == 2 * N_RANDOM / 3) begin
                send_pct = 0;
                recv_pct = 0;
            end else if (rand_idx == 5 * N_RANDOM / 6) begin
                hold_req = 1'b1;   // receiver stalls while bytes keep coming
            end
            gap = 0;
            while (gap < 40 && $urandom_range(99) < send_pct) gap++;
            // drain completely after the directed part and at the first phase change
            if (rand_idx == 0 || rand_idx == N_RANDOM / 3) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (exp_units_q.size() != 0) @(negedge aclk);
            end else if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            cur_typed = item.typed;
            cur_unit  = item.unit;
            s_tvalid <= 1'b1;
            s_tdata  <= item.data;
            s_tlast  <= item.fin;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            @(negedge aclk);
        end
        s_tvalid <= 1'b0;
        while (exp_units_q.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
        if (err_cnt == 0 && exp_units_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
